// ===== rtl/core/hce_pkg.sv =====
// shared types and constants of the huffman codec engine
`default_nettype none

package hce_pkg;

  localparam int unsigned SYM_W      = 7;
  localparam int unsigned NODE_W     = 8;
  localparam int unsigned CNT_W      = 16;
  localparam int unsigned CODE_W     = 32;
  localparam int unsigned LEN_W      = 6;
  localparam int unsigned HEAP_AW    = 7;
  localparam int unsigned ALPHABET   = 128;
  localparam int unsigned NODE_COUNT = 2 * ALPHABET - 1;

  localparam logic [CNT_W-1:0]  COUNT_MAX  = '1;
  localparam logic [NODE_W-1:0] FIRST_NODE = NODE_W'(ALPHABET);
  localparam logic [LEN_W-1:0]  LEN_MAX    = LEN_W'(CODE_W);

  typedef enum logic [2:0] {
    CMD_COUNT  = 3'd0,
    CMD_BUILD  = 3'd1,
    CMD_ENCODE = 3'd2,
    CMD_DECODE = 3'd3,
    CMD_CLEAR  = 3'd4
  } cmd_e;

  typedef enum logic [2:0] {
    ST_OK       = 3'd0,
    ST_UNSUP    = 3'd1,
    ST_ABSENT   = 3'd2,
    ST_DEC_ERR  = 3'd3,
    ST_NO_TREE  = 3'd4,
    ST_OVERFLOW = 3'd5
  } status_e;

  typedef struct packed {
    logic [CNT_W-1:0]  weight;
    logic [NODE_W-1:0] node;
  } heap_ent_t;

  typedef struct packed {
    logic [2:0]        status;
    logic [SYM_W-1:0]  dsym;
    logic              sym_valid;
    logic [CODE_W-1:0] code_word;
    logic [LEN_W-1:0]  code_len;
  } result_t;

endpackage

`default_nettype wire

// ===== rtl/core/hce_alu.sv =====
// shared weight compare and add unit
`default_nettype none

module hce_alu (
  input  wire logic [hce_pkg::CNT_W-1:0] a_i,
  input  wire logic [hce_pkg::CNT_W-1:0] b_i,
  output logic                           gt_o,
  output logic [hce_pkg::CNT_W-1:0]      sum_o
);

  assign gt_o  = (a_i > b_i);
  assign sum_o = a_i + b_i;

endmodule

`default_nettype wire

// ===== rtl/core/huffman_codec_engine.sv =====
// huffman codec engine top level: command sequencer, tables and heap
// count, encode and decode: the result goes from S_CNT, S_ENC or S_DEC through S_DONE to the output
//   register, early errors straight from S_IDLE to S_DONE; S_DONE waits while the output is held
// build: a scan of symbol slots 1 to 127 through S_SCAN_RD and S_SCAN_WR, then heap sift
//   steps through one shared compare and add unit, then S_CD_RD, S_CD_L and S_CD_R per
//   internal node for code derivation
// one item at a time; ready only while the sequencer is idle
// reset clears counts, tree state and the frequency valid bits; clear does the same
`default_nettype none

module huffman_codec_engine (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [15:0] s_axis_tdata,  // symbol[7:0], code_bit[8]
  input  wire logic [2:0]  s_axis_tuser,  // command[2:0]
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [47:0]      m_axis_tdata,  // decoded_symbol[6:0], code_word[38:7], code_length[44:39]
  output logic [3:0]       m_axis_tuser   // status[2:0], symbol_valid[3]
);

  localparam int unsigned CW = hce_pkg::CODE_W;
  localparam int unsigned LW = hce_pkg::LEN_W;
  localparam int unsigned NW = hce_pkg::NODE_W;
  localparam int unsigned AW = hce_pkg::HEAP_AW;
  localparam int unsigned KW = hce_pkg::CNT_W;

  typedef enum logic [4:0] {
    S_IDLE, S_CNT, S_ENC, S_DEC, S_DONE, S_SCAN_RD, S_SCAN_WR, S_HEAPIFY,
    S_SD_LOAD, S_SD_TEST, S_SD_L, S_SD_R, S_SD_MOVE, S_MERGE, S_POP_TOP,
    S_POP_LAST, S_NEW, S_SU_TEST, S_SU_CMP, S_ROOT, S_CD_RD, S_CD_L, S_CD_R
  } state_e;

  typedef enum logic [1:0] {R_HEAPIFY, R_POP1, R_POP2} ret_e;

  // memories
  logic [KW-1:0]       freq_mem [hce_pkg::ALPHABET];
  hce_pkg::heap_ent_t  heap_mem [hce_pkg::ALPHABET];
  logic [2*NW-1:0]     child_mem [hce_pkg::NODE_COUNT];
  logic [LW+CW-1:0]    code_mem [hce_pkg::NODE_COUNT];

  logic                freq_re, freq_we, freq_vld_q;
  logic [AW-1:0]       freq_ra, freq_wa;
  logic [KW-1:0]       freq_wd, freq_rd_q;
  logic                heap_re, heap_we;
  logic [AW-1:0]       heap_ra, heap_wa;
  hce_pkg::heap_ent_t  heap_wd, heap_rd_q;
  logic                child_re, child_we;
  logic [NW-1:0]       child_ra, child_wa;
  logic [2*NW-1:0]     child_wd, child_rd_q;
  logic                code_re, code_we;
  logic [NW-1:0]       code_ra, code_wa;
  logic [LW+CW-1:0]    code_wd, code_rd_q;

  state_e              state_q, state_d;
  ret_e                ret_q, ret_d;
  logic [hce_pkg::ALPHABET-1:0] fv_q, fv_d;
  logic [KW-1:0]       total_q, total_d;
  logic [NW-1:0]       hsize_q, hsize_d, root_q, root_d, walk_q, walk_d;
  logic [NW-1:0]       next_q, next_d, cn_q, cn_d, k_q, k_d;
  logic                ready_q, ready_d;
  logic [AW-1:0]       scan_q, scan_d, pos_q, pos_d, cpos_q, cpos_d;
  logic                self_q, self_d, bit_q, bit_d;
  logic [7:0]          sym_q, sym_d;
  hce_pkg::heap_ent_t  x_q, x_d, cand_q, cand_d, a_q, a_d, tmp_q, tmp_d;
  hce_pkg::result_t    res_q, res_d, out_q, out_d;
  logic                out_vld_q, out_vld_d;

  logic [KW-1:0]       alu_a, alu_b, alu_sum;
  logic                alu_gt;

  logic [NW-1:0]       lpos, rpos, scan_size, child_sel;
  logic [AW-1:0]       ppos;
  logic [LW-1:0]       nlen;
  logic                sd_done, sym_ok;
  logic [7:0]          in_sym;

  hce_alu u_alu (
    .a_i  (alu_a),
    .b_i  (alu_b),
    .gt_o (alu_gt),
    .sum_o(alu_sum)
  );

  assign lpos      = {pos_q, 1'b1};
  assign rpos      = {pos_q, 1'b0} + NW'(2);
  assign ppos      = AW'((pos_q - AW'(1)) >> 1);
  assign nlen      = (code_rd_q[LW+CW-1:CW] < hce_pkg::LEN_MAX) ?
                     code_rd_q[LW+CW-1:CW] + LW'(1) : hce_pkg::LEN_MAX;
  assign child_sel = bit_q ? child_rd_q[2*NW-1:NW] : child_rd_q[NW-1:0];
  assign in_sym    = s_axis_tdata[7:0];
  assign sym_ok    = (in_sym != 8'd0) && !in_sym[7];
  assign scan_size = hsize_q + NW'(freq_vld_q && (freq_rd_q != '0));

  assign s_axis_tready = (state_q == S_IDLE);
  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = {3'b000, out_q.code_len, out_q.code_word, out_q.dsym};
  assign m_axis_tuser  = {out_q.sym_valid, out_q.status};

  always_comb begin
    state_d   = state_q;
    ret_d     = ret_q;
    fv_d      = fv_q;
    total_d   = total_q;
    hsize_d   = hsize_q;
    root_d    = root_q;
    walk_d    = walk_q;
    next_d    = next_q;
    cn_d      = cn_q;
    k_d       = k_q;
    ready_d   = ready_q;
    scan_d    = scan_q;
    pos_d     = pos_q;
    cpos_d    = cpos_q;
    self_d    = self_q;
    bit_d     = bit_q;
    sym_d     = sym_q;
    x_d       = x_q;
    cand_d    = cand_q;
    a_d       = a_q;
    tmp_d     = tmp_q;
    res_d     = res_q;
    out_d     = out_q;
    out_vld_d = out_vld_q && !m_axis_tready;
    freq_re = 1'b0; freq_ra = '0; freq_we = 1'b0; freq_wa = '0; freq_wd = '0;
    heap_re = 1'b0; heap_ra = '0; heap_we = 1'b0; heap_wa = '0; heap_wd = '0;
    child_re = 1'b0; child_ra = '0; child_we = 1'b0; child_wa = '0; child_wd = '0;
    code_re = 1'b0; code_ra = '0; code_we = 1'b0; code_wa = '0; code_wd = '0;
    alu_a   = x_q.weight;
    alu_b   = heap_rd_q.weight;
    sd_done = 1'b0;

    case (state_q)
      S_IDLE: begin
        if (s_axis_tvalid) begin
          res_d = '0;
          sym_d = in_sym;
          bit_d = s_axis_tdata[8];
          state_d = S_DONE;
          case (s_axis_tuser)
            hce_pkg::CMD_COUNT: begin
              if (!sym_ok) begin
                res_d.status = hce_pkg::ST_UNSUP;
              end else if (total_q == hce_pkg::COUNT_MAX) begin
                res_d.status = hce_pkg::ST_OVERFLOW;
              end else begin
                freq_re = 1'b1;
                freq_ra = in_sym[AW-1:0];
                state_d = S_CNT;
              end
            end
            hce_pkg::CMD_BUILD: begin
              ready_d = 1'b0;
              hsize_d = '0;
              scan_d  = AW'(1);
              state_d = S_SCAN_RD;
            end
            hce_pkg::CMD_ENCODE: begin
              if (!sym_ok) begin
                res_d.status = hce_pkg::ST_UNSUP;
              end else if (!ready_q) begin
                res_d.status = hce_pkg::ST_NO_TREE;
              end else begin
                freq_re = 1'b1;
                freq_ra = in_sym[AW-1:0];
                code_re = 1'b1;
                code_ra = {1'b0, in_sym[AW-1:0]};
                state_d = S_ENC;
              end
            end
            hce_pkg::CMD_DECODE: begin
              if (!ready_q) begin
                res_d.status = hce_pkg::ST_NO_TREE;
              end else if (!walk_q[NW-1]) begin
                res_d.status = hce_pkg::ST_DEC_ERR;
                walk_d = root_q;
              end else begin
                child_re = 1'b1;
                child_ra = walk_q;
                state_d  = S_DEC;
              end
            end
            hce_pkg::CMD_CLEAR: begin
              fv_d    = '0;
              total_d = '0;
              hsize_d = '0;
              root_d  = '0;
              ready_d = 1'b0;
              walk_d  = '0;
            end
            default: ;
          endcase
        end
      end
      S_CNT: begin
        alu_a   = freq_vld_q ? freq_rd_q : '0;
        alu_b   = KW'(1);
        freq_we = 1'b1;
        freq_wa = sym_q[AW-1:0];
        freq_wd = alu_sum;
        fv_d[sym_q[AW-1:0]] = 1'b1;
        total_d = total_q + KW'(1);
        ready_d = 1'b0;
        state_d = S_DONE;
      end
      S_ENC: begin
        if (!freq_vld_q || (freq_rd_q == '0)) begin
          res_d.status = hce_pkg::ST_ABSENT;
        end else begin
          res_d.code_word = code_rd_q[CW-1:0];
          res_d.code_len  = code_rd_q[LW+CW-1:CW];
        end
        state_d = S_DONE;
      end
      S_DEC: begin
        if (!child_sel[NW-1]) begin
          res_d.dsym      = child_sel[hce_pkg::SYM_W-1:0];
          res_d.sym_valid = 1'b1;
          walk_d = root_q;
        end else begin
          walk_d = child_sel;
        end
        state_d = S_DONE;
      end
      S_DONE: begin
        if (!out_vld_q || m_axis_tready) begin
          out_d     = res_q;
          out_vld_d = 1'b1;
          state_d   = S_IDLE;
        end
      end
      S_SCAN_RD: begin
        freq_re = 1'b1;
        freq_ra = scan_q;
        state_d = S_SCAN_WR;
      end
      S_SCAN_WR: begin
        if (freq_vld_q && (freq_rd_q != '0)) begin
          heap_we = 1'b1;
          heap_wa = hsize_q[AW-1:0];
          heap_wd = '{weight: freq_rd_q, node: {1'b0, scan_q}};
        end
        hsize_d = scan_size;
        if (scan_q == '1) begin
          if (scan_size == '0) begin
            res_d.status = hce_pkg::ST_NO_TREE;
            state_d = S_DONE;
          end else begin
            k_d     = scan_size >> 1;
            state_d = S_HEAPIFY;
          end
        end else begin
          scan_d  = scan_q + AW'(1);
          state_d = S_SCAN_RD;
        end
      end
      S_HEAPIFY: begin
        if (k_q == '0) begin
          next_d  = hce_pkg::FIRST_NODE;
          state_d = S_MERGE;
        end else begin
          heap_re = 1'b1;
          heap_ra = AW'(k_q - NW'(1));
          pos_d   = AW'(k_q - NW'(1));
          k_d     = k_q - NW'(1);
          ret_d   = R_HEAPIFY;
          state_d = S_SD_LOAD;
        end
      end
      S_SD_LOAD: begin
        x_d     = heap_rd_q;
        state_d = S_SD_TEST;
      end
      S_SD_TEST: begin
        if (lpos < hsize_q) begin
          heap_re = 1'b1;
          heap_ra = lpos[AW-1:0];
          state_d = S_SD_L;
        end else begin
          heap_we = 1'b1;
          heap_wa = pos_q;
          heap_wd = x_q;
          sd_done = 1'b1;
        end
      end
      S_SD_L: begin
        if (alu_gt) begin
          cand_d = heap_rd_q;
          cpos_d = lpos[AW-1:0];
          self_d = 1'b0;
        end else begin
          cand_d = x_q;
          self_d = 1'b1;
        end
        if (rpos < hsize_q) begin
          heap_re = 1'b1;
          heap_ra = rpos[AW-1:0];
          state_d = S_SD_R;
        end else begin
          state_d = S_SD_MOVE;
        end
      end
      S_SD_R: begin
        alu_a = cand_q.weight;
        if (alu_gt) begin
          cand_d = heap_rd_q;
          cpos_d = rpos[AW-1:0];
          self_d = 1'b0;
        end
        state_d = S_SD_MOVE;
      end
      S_SD_MOVE: begin
        heap_we = 1'b1;
        heap_wa = pos_q;
        if (self_q) begin
          heap_wd = x_q;
          sd_done = 1'b1;
        end else begin
          heap_wd = cand_q;
          pos_d   = cpos_q;
          state_d = S_SD_TEST;
        end
      end
      S_MERGE: begin
        heap_re = 1'b1;
        heap_ra = '0;
        if (hsize_q > NW'(1)) begin
          ret_d   = R_POP1;
          state_d = S_POP_TOP;
        end else begin
          state_d = S_ROOT;
        end
      end
      S_POP_TOP: begin
        tmp_d   = heap_rd_q;
        hsize_d = hsize_q - NW'(1);
        heap_re = 1'b1;
        heap_ra = AW'(hsize_q - NW'(1));
        state_d = S_POP_LAST;
      end
      S_POP_LAST: begin
        x_d     = heap_rd_q;
        pos_d   = '0;
        state_d = S_SD_TEST;
      end
      S_NEW: begin
        alu_a    = a_q.weight;
        alu_b    = tmp_q.weight;
        child_we = 1'b1;
        child_wa = next_q;
        child_wd = {tmp_q.node, a_q.node};
        x_d      = '{weight: alu_sum, node: next_q};
        pos_d    = hsize_q[AW-1:0];
        hsize_d  = hsize_q + NW'(1);
        next_d   = next_q + NW'(1);
        state_d  = S_SU_TEST;
      end
      S_SU_TEST: begin
        if (pos_q == '0) begin
          heap_we = 1'b1;
          heap_wa = pos_q;
          heap_wd = x_q;
          state_d = S_MERGE;
        end else begin
          heap_re = 1'b1;
          heap_ra = ppos;
          state_d = S_SU_CMP;
        end
      end
      S_SU_CMP: begin
        alu_a   = heap_rd_q.weight;
        alu_b   = x_q.weight;
        heap_we = 1'b1;
        heap_wa = pos_q;
        if (alu_gt) begin
          heap_wd = heap_rd_q;
          pos_d   = ppos;
          state_d = S_SU_TEST;
        end else begin
          heap_wd = x_q;
          state_d = S_MERGE;
        end
      end
      S_ROOT: begin
        root_d  = heap_rd_q.node;
        code_we = 1'b1;
        code_wa = heap_rd_q.node;
        code_wd = '0;
        if (heap_rd_q.node[NW-1]) begin
          cn_d    = heap_rd_q.node;
          state_d = S_CD_RD;
        end else begin
          ready_d = 1'b1;
          walk_d  = heap_rd_q.node;
          state_d = S_DONE;
        end
      end
      S_CD_RD: begin
        code_re  = 1'b1;
        code_ra  = cn_q;
        child_re = 1'b1;
        child_ra = cn_q;
        state_d  = S_CD_L;
      end
      S_CD_L: begin
        code_we = 1'b1;
        code_wa = child_rd_q[NW-1:0];
        code_wd = {nlen, code_rd_q[CW-2:0], 1'b0};
        state_d = S_CD_R;
      end
      S_CD_R: begin
        code_we = 1'b1;
        code_wa = child_rd_q[2*NW-1:NW];
        code_wd = {nlen, code_rd_q[CW-2:0], 1'b1};
        if (cn_q == hce_pkg::FIRST_NODE) begin
          ready_d = 1'b1;
          walk_d  = root_q;
          state_d = S_DONE;
        end else begin
          cn_d    = cn_q - NW'(1);
          state_d = S_CD_RD;
        end
      end
      default: state_d = S_IDLE;
    endcase

    if (sd_done) begin
      case (ret_q)
        R_HEAPIFY: state_d = S_HEAPIFY;
        R_POP1: begin
          a_d     = tmp_q;
          heap_re = 1'b1;
          heap_ra = '0;
          ret_d   = R_POP2;
          state_d = S_POP_TOP;
        end
        R_POP2:  state_d = S_NEW;
        default: state_d = S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      ret_q     <= R_HEAPIFY;
      fv_q      <= '0;
      total_q   <= '0;
      hsize_q   <= '0;
      root_q    <= '0;
      walk_q    <= '0;
      next_q    <= '0;
      cn_q      <= '0;
      k_q       <= '0;
      ready_q   <= 1'b0;
      scan_q    <= '0;
      pos_q     <= '0;
      cpos_q    <= '0;
      self_q    <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      ret_q     <= ret_d;
      fv_q      <= fv_d;
      total_q   <= total_d;
      hsize_q   <= hsize_d;
      root_q    <= root_d;
      walk_q    <= walk_d;
      next_q    <= next_d;
      cn_q      <= cn_d;
      k_q       <= k_d;
      ready_q   <= ready_d;
      scan_q    <= scan_d;
      pos_q     <= pos_d;
      cpos_q    <= cpos_d;
      self_q    <= self_d;
      out_vld_q <= out_vld_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    bit_q  <= bit_d;
    sym_q  <= sym_d;
    x_q    <= x_d;
    cand_q <= cand_d;
    a_q    <= a_d;
    tmp_q  <= tmp_d;
    res_q  <= res_d;
    out_q  <= out_d;
  end

  always_ff @(posedge clk_i) begin
    if (freq_we) begin
      freq_mem[freq_wa] <= freq_wd;
    end
    if (freq_re) begin
      freq_rd_q  <= freq_mem[freq_ra];
      freq_vld_q <= fv_q[freq_ra];
    end
  end

  // write-first: a read of the slot written in the same cycle sees the new entry
  always_ff @(posedge clk_i) begin
    if (heap_we) begin
      heap_mem[heap_wa] <= heap_wd;
    end
    if (heap_re) begin
      heap_rd_q <= (heap_we && (heap_wa == heap_ra)) ? heap_wd : heap_mem[heap_ra];
    end
  end

  always_ff @(posedge clk_i) begin
    if (child_we) begin
      child_mem[child_wa] <= child_wd;
    end
    if (child_re) begin
      child_rd_q <= child_mem[child_ra];
    end
  end

  always_ff @(posedge clk_i) begin
    if (code_we) begin
      code_mem[code_wa] <= code_wd;
    end
    if (code_re) begin
      code_rd_q <= code_mem[code_ra];
    end
  end

  a_heap_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    hsize_q <= NW'(hce_pkg::ALPHABET - 1))
    else $error("heap size beyond alphabet");

  a_walk_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ready_q |-> (walk_q[NW-1] || (walk_q == root_q)))
    else $error("walk position off tree");

  a_sym_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tuser[3]) |-> (m_axis_tuser[2:0] == hce_pkg::ST_OK))
    else $error("decoded symbol with error status");

  a_len_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (out_q.code_len <= hce_pkg::LEN_MAX))
    else $error("code length too long");

  a_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
    else $error("accepted a second item while busy");

endmodule

`default_nettype wire
